// File: sv/rfeb_pkg.sv
// Shared types and constants for the readout frame event builder.
`timescale 1ns / 1ps
`default_nettype none

package rfeb_pkg;

  // Field widths of one readout word and of one result word.
  localparam int unsigned WordW  = 32;
  localparam int unsigned ChW    = 6;
  localparam int unsigned ValW   = 13;
  localparam int unsigned ScW    = 15;
  localparam int unsigned CountW = 12;

  // Masks and match patterns that sort a data word into its kind.
  localparam logic [WordW-1:0] AdcMask   = 32'h0068_0000;
  localparam logic [WordW-1:0] AdcHiPat  = 32'h0000_0000;
  localparam logic [WordW-1:0] AdcLoPat  = 32'h0008_0000;
  localparam logic [WordW-1:0] TdcMask   = 32'h0060_1000;
  localparam logic [WordW-1:0] TdcLePat  = 32'h0020_1000;
  localparam logic [WordW-1:0] TdcTrPat  = 32'h0020_0000;
  localparam logic [WordW-1:0] ScMask    = 32'h0060_0000;
  localparam logic [WordW-1:0] ScPat     = 32'h0040_0000;

  // Bit positions inside a readout word.
  localparam int unsigned HeaderBit = 27;
  localparam int unsigned OtrBit    = 12;

  // Value that marks an absent entry.
  localparam logic [ValW-1:0] Absent13 = '1;
  localparam logic [ScW-1:0]  Absent15 = '1;

  // Indices of the per-kind write enables.
  localparam int unsigned KindHg = 0;
  localparam int unsigned KindLg = 1;
  localparam int unsigned KindLe = 2;
  localparam int unsigned KindTr = 3;
  localparam int unsigned KindSc = 4;
  localparam int unsigned Kinds  = 5;

  // Access request from the sequencer to the channel stores.
  typedef struct packed {
    logic [Kinds-1:0] wr_en;
    logic             clr;
    logic             rd;
    logic [ChW-1:0]   addr;
    logic [ScW-2:0]   val;
  } store_cmd_t;

  // Registered read data of one channel.
  typedef struct packed {
    logic [ValW-1:0] hg;
    logic [ValW-1:0] lg;
    logic [ValW-1:0] le;
    logic [ValW-1:0] tr;
    logic [ScW-1:0]  sc;
  } store_rd_t;

  // Control part of a result word, aligned with the store read data.
  typedef struct packed {
    logic           vld;
    logic           err;
    logic           last;
    logic [ChW-1:0] ch;
  } res_ctl_t;

endpackage

`default_nettype wire

// File: sv/rfeb_store.sv
// Per-channel value stores: five synchronous memories with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rfeb_store #(
  parameter int unsigned CHANNELS = 64
) (
  input  wire logic                clk_i,
  input  wire rfeb_pkg::store_cmd_t cmd_i,
  output      rfeb_pkg::store_rd_t  rd_o
);

  import rfeb_pkg::*;

  localparam int unsigned AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [ValW-1:0] hg_mem [CHANNELS];
  logic [ValW-1:0] lg_mem [CHANNELS];
  logic [ValW-1:0] le_mem [CHANNELS];
  logic [ValW-1:0] tr_mem [CHANNELS];
  logic [ScW-1:0]  sc_mem [CHANNELS];

  logic [AddrW-1:0] addr;
  logic [ValW-1:0]  val12;
  logic [ScW-1:0]   val14;
  store_rd_t        rd_q;

  assign addr  = cmd_i.addr[AddrW-1:0];
  assign val12 = {1'b0, cmd_i.val[CountW-1:0]};
  assign val14 = {1'b0, cmd_i.val};

  // Write port: a clear writes the absent mark to every kind of one channel.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      hg_mem[addr] <= Absent13;
      lg_mem[addr] <= Absent13;
      le_mem[addr] <= Absent13;
      tr_mem[addr] <= Absent13;
      sc_mem[addr] <= Absent15;
    end else begin
      if (cmd_i.wr_en[KindHg]) hg_mem[addr] <= val12;
      if (cmd_i.wr_en[KindLg]) lg_mem[addr] <= val12;
      if (cmd_i.wr_en[KindLe]) le_mem[addr] <= val12;
      if (cmd_i.wr_en[KindTr]) tr_mem[addr] <= val12;
      if (cmd_i.wr_en[KindSc]) sc_mem[addr] <= val14;
    end
  end

  // Read port: returns the old contents when a clear hits the same channel.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      rd_q.hg <= hg_mem[addr];
      rd_q.lg <= lg_mem[addr];
      rd_q.le <= le_mem[addr];
      rd_q.tr <= tr_mem[addr];
      rd_q.sc <= sc_mem[addr];
    end
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

// File: sv/rfeb_ctrl.sv
// Frame sequencer: header parsing, data word sorting, dump and clearing sweeps.
`timescale 1ns / 1ps
`default_nettype none

module rfeb_ctrl #(
  parameter int unsigned CHANNELS = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [31:0]          data_word_i,
  output      logic                 busy_o,
  output      rfeb_pkg::store_cmd_t cmd_o,
  output      rfeb_pkg::res_ctl_t   res_o
);

  import rfeb_pkg::*;

  localparam int unsigned CntW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CntW-1:0] CntEnd = CntW'(CHANNELS - 1);
  localparam logic [ChW:0]    ChLimit = (ChW + 1)'(CHANNELS);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_HEADER,
    ST_DATA,
    ST_DUMP
  } state_e;

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CountW-1:0] left_q, left_d;
  res_ctl_t          res_q, res_d;

  logic             accept;
  logic             otr;
  logic [ChW-1:0]   ch;
  logic [ChW:0]     sc_ch;
  logic             ch_ok;
  logic             sc_ok;
  logic [Kinds-1:0] kind;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q == ST_CLEAR) || (state_q == ST_DUMP);

  // Sort the incoming word; the kinds are tested in priority order.
  assign otr   = data_word_i[OtrBit];
  assign ch    = data_word_i[18:13];
  assign sc_ch = data_word_i[20:14];
  assign ch_ok = {1'b0, ch} < ChLimit;
  assign sc_ok = sc_ch < ChLimit;

  always_comb begin
    kind = '0;
    priority if ((data_word_i & AdcMask) == AdcHiPat) begin
      kind[KindHg] = !otr && ch_ok;
    end else if ((data_word_i & AdcMask) == AdcLoPat) begin
      kind[KindLg] = !otr && ch_ok;
    end else if ((data_word_i & TdcMask) == TdcLePat) begin
      kind[KindLe] = ch_ok;
    end else if ((data_word_i & TdcMask) == TdcTrPat) begin
      kind[KindTr] = ch_ok;
    end else if ((data_word_i & ScMask) == ScPat) begin
      kind[KindSc] = sc_ok;
    end else begin
      // An unknown word writes nothing.
      kind = '0;
    end
  end

  // Next state, store requests and the control half of the next result.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    left_d  = left_q;
    res_d   = '0;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr  = 1'b1;
        cmd_o.addr = ChW'(cnt_q);
        if (cnt_q == CntEnd) begin
          cnt_d   = '0;
          state_d = ST_HEADER;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_HEADER: begin
        if (accept) begin
          if (!data_word_i[HeaderBit]) begin
            res_d.vld  = 1'b1;
            res_d.err  = 1'b1;
            res_d.last = 1'b1;
          end else if (data_word_i[CountW-1:0] == '0) begin
            cnt_d   = '0;
            state_d = ST_DUMP;
          end else begin
            left_d  = data_word_i[CountW-1:0];
            state_d = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (accept) begin
          cmd_o.wr_en = kind;
          cmd_o.addr  = kind[KindSc] ? sc_ch[ChW-1:0] : ch;
          cmd_o.val   = kind[KindSc] ? data_word_i[ScW-2:0]
                                     : {2'b00, data_word_i[CountW-1:0]};
          left_d = left_q - 1'b1;
          if (left_q == CountW'(1)) begin
            cnt_d   = '0;
            state_d = ST_DUMP;
          end
        end
      end
      ST_DUMP: begin
        // Read a channel out and clear it in the same cycle.
        cmd_o.rd   = 1'b1;
        cmd_o.clr  = 1'b1;
        cmd_o.addr = ChW'(cnt_q);
        res_d.vld  = 1'b1;
        res_d.ch   = ChW'(cnt_q);
        res_d.last = (cnt_q == CntEnd);
        if (cnt_q == CntEnd) begin
          cnt_d   = '0;
          state_d = ST_HEADER;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // State and registered result control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      left_q  <= '0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      res_q   <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// File: sv/readout_frame_event_builder_unit.sv
// Top level of the readout frame event builder.
//
//   Channel   Direction  Handshake                 Payload
//   command   in         start_i, busy_o           data_word_i
//   result    out        result_valid_o (strobe)   channel_o, adc_*_o, tdc_*_o,
//                                                  scaler_count_o, frame_error_o,
//                                                  last_of_event_o
//
// Header and data words of a frame may arrive back to back.
// The closing word of a frame, or an empty header, starts a dump that keeps busy_o
// high until it has made one memory read per channel; each result word leaves in the
// cycle after its read. A bad header gives its single error word in the next cycle.
// After reset a clearing pass over all channels holds busy_o high.
// Result words are strobed for one cycle each; the receiver cannot stall them.
`timescale 1ns / 1ps
`default_nettype none

module readout_frame_event_builder_unit #(
  parameter int unsigned CHANNELS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output      logic        busy_o,
  input  wire logic [31:0] data_word_i,
  output      logic        result_valid_o,
  output      logic [5:0]  channel_o,
  output      logic signed [12:0] adc_high_gain_o,
  output      logic signed [12:0] adc_low_gain_o,
  output      logic signed [12:0] tdc_leading_o,
  output      logic signed [12:0] tdc_trailing_o,
  output      logic signed [14:0] scaler_count_o,
  output      logic        frame_error_o,
  output      logic        last_of_event_o
);

  import rfeb_pkg::*;

  store_cmd_t cmd;
  store_rd_t  rd;
  res_ctl_t   res;

  rfeb_ctrl #(
    .CHANNELS(CHANNELS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .data_word_i(data_word_i),
    .busy_o     (busy_o),
    .cmd_o      (cmd),
    .res_o      (res)
  );

  rfeb_store #(
    .CHANNELS(CHANNELS)
  ) u_store (
    .clk_i(clk_i),
    .cmd_i(cmd),
    .rd_o (rd)
  );

  // An error word carries the absent mark in every value field.
  assign result_valid_o  = res.vld;
  assign frame_error_o   = res.err;
  assign last_of_event_o = res.last;
  assign channel_o       = res.err ? '0 : res.ch;
  assign adc_high_gain_o = $signed(res.err ? Absent13 : rd.hg);
  assign adc_low_gain_o  = $signed(res.err ? Absent13 : rd.lg);
  assign tdc_leading_o   = $signed(res.err ? Absent13 : rd.le);
  assign tdc_trailing_o  = $signed(res.err ? Absent13 : rd.tr);
  assign scaler_count_o  = $signed(res.err ? Absent15 : rd.sc);

endmodule

`default_nettype wire

// File: sv/rfeb_checker.sv
// Port-level checks for the readout frame event builder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rfeb_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start_i,
  input wire logic        busy_o,
  input wire logic        result_valid_o,
  input wire logic [5:0]  channel_o,
  input wire logic [12:0] adc_high_gain_o,
  input wire logic [14:0] scaler_count_o,
  input wire logic        frame_error_o,
  input wire logic        last_of_event_o
);

  // An error word closes its event, names channel zero and carries absent values.
  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && frame_error_o |->
      last_of_event_o && (channel_o == 6'd0) &&
      (adc_high_gain_o == 13'h1fff) && (scaler_count_o == 15'h7fff))
    else $error("error word malformed");

  // An error word answers the word accepted in the cycle before.
  a_err_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && frame_error_o |-> $past(start_i && !busy_o))
    else $error("error word without an accepted header");

  // Dump words come from reads made while the block was busy.
  a_dump_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !frame_error_o |-> $past(busy_o))
    else $error("dump word outside a dump");

  // A dump runs without gaps until its last word.
  a_dump_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_of_event_o |=> result_valid_o && !frame_error_o)
    else $error("dump interrupted");

endmodule

bind readout_frame_event_builder_unit rfeb_checker u_rfeb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .channel_o      (channel_o),
  .adc_high_gain_o(adc_high_gain_o),
  .scaler_count_o (scaler_count_o),
  .frame_error_o  (frame_error_o),
  .last_of_event_o(last_of_event_o)
);

`default_nettype wire
